[sv/lswg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lswg_pkg
// Shared types, constants and elaboration-time tables for the scan generator.
// ----------------------------------------------------------------------------
package lswg_pkg;

	localparam int SINE_TABLE_DEPTH = 256;   // entries per turn, multiple of 4
	localparam int PHASE_BITS       = 32;

	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
	localparam int QSPAN  = SINE_TABLE_DEPTH / 4;
	localparam int STEP_UP = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
	localparam int STEP_DN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_AMP  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_AMP  = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFS   = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE  = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COLOUR = 8'd7;

	localparam logic [15:0] AMP_FULL   = 16'd32768;
	localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
	localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;
	localparam logic [11:0] POS_MAX    = 12'd4095;
	localparam logic [7:0]  COLOUR_MAX = 8'd31;

	// Taylor series divisors, innermost first, and their 2^32 reciprocals
	localparam int unsigned KDIV [5] = '{110, 72, 42, 20, 6};
	localparam logic [31:0] KREC [5] = '{
		32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
		32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd20),
		32'((64'd1 << 32) / 64'd6)};

	typedef struct packed {
		logic [31:0]        x_step;
		logic [31:0]        y_step;
		logic [15:0]        x_amp;
		logic [15:0]        y_amp;
		logic signed [12:0] x_off;
		logic signed [12:0] y_off;
		logic [15:0]        angle;
		logic [11:0]        cx;
		logic [11:0]        cy;
		logic [4:0]         red;
		logic [4:0]         green;
		logic [4:0]         blue;
	} cfg_t;

	typedef struct packed {
		logic signed [33:0] a;
		logic signed [33:0] b;
	} mul_req_t;

	typedef logic [16:0] wave_lut_t [SINE_TABLE_DEPTH];

	// Elaboration-time sine kernel, same arithmetic as the run-time sequence.
	function automatic longint unsigned kern_c(longint unsigned x);
		longint unsigned x2, t, q, s;
		x2 = (x * x) >> 30;
		t  = 64'd1 << 30;
		for (int n = 0; n < 5; n++) begin
			q = ((x2 * t) >> 30) / KDIV[n];
			t = (q > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - q;
		end
		s = (x * t) >> 30;
		q = (s + 64'd16384) >> 15;
		if (q > 64'd32768) q = 64'd32768;
		return q;
	endfunction

	// Full wave, offset by one half: entry holds sin + 32768 (0..65536).
	function automatic wave_lut_t build_wave();
		wave_lut_t w;
		longint unsigned k, x, v;
		int quad, r;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			quad = (i / QSPAN) % 4;
			r    = i % QSPAN;
			k    = (quad % 2 == 1) ? longint'(QSPAN - r) : longint'(r);
			x    = (k * longint'(PI_HALF_Q30)) / QSPAN;
			v    = kern_c(x);
			w[i] = (quad >= 2) ? 17'(64'd32768 - v) : 17'(64'd32768 + v);
		end
		return w;
	endfunction

	localparam wave_lut_t WAVE_LUT = build_wave();

	function automatic logic [PHASE_BITS-1:0] align_step(input logic [31:0] s);
		logic [PHASE_BITS+31:0] w;
		w = (PHASE_BITS + 32)'(s) << STEP_UP;
		w = w >> STEP_DN;
		return w[PHASE_BITS-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] wave_index(input logic [PHASE_BITS-1:0] ph);
		logic [PHASE_BITS+IDX_W-1:0] m;
		m = (PHASE_BITS + IDX_W)'(ph) * (PHASE_BITS + IDX_W)'(SINE_TABLE_DEPTH);
		return m[PHASE_BITS+IDX_W-1:PHASE_BITS];
	endfunction

	// round the Q30 axis product, add the offset, saturate to 0..4095
	function automatic logic [11:0] axis_pos(input logic [42:0] m,
	                                        input logic signed [12:0] off);
		logic [43:0] r;
		logic signed [15:0] sum;
		r   = 44'(m) + 44'(64'd1 << 29);
		sum = $signed({2'b00, r[43:30]}) + 16'(off);
		if (sum < 0) return 12'd0;
		if (sum > $signed({4'd0, POS_MAX})) return POS_MAX;
		return sum[11:0];
	endfunction

	function automatic logic [11:0] round_clamp(input logic signed [39:0] q15);
		logic [39:0] v;
		if (q15 < 0) return 12'd0;
		v = (40'(q15) + 40'd16384) >> 15;
		return (v > 40'(POS_MAX)) ? POS_MAX : v[11:0];
	endfunction

	function automatic logic [4:0] sat_colour(input logic [7:0] c);
		return (c > COLOUR_MAX) ? COLOUR_MAX[4:0] : c[4:0];
	endfunction

endpackage

[sv/lswg_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lswg_cfg
// Configuration register file; presents decoded, saturated fields.
// ----------------------------------------------------------------------------
module lswg_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lswg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lswg_pkg::CFG_DATA_W-1:0]  cfg_data,
	output lswg_pkg::cfg_t                   cfg
);
	import lswg_pkg::*;

	logic [31:0] x_step_q, y_step_q;
	logic [15:0] x_amp_q, y_amp_q, angle_q;
	logic [25:0] offs_q;
	logic [23:0] center_q, colour_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_step_q <= '0;
			y_step_q <= '0;
			x_amp_q  <= '0;
			y_amp_q  <= '0;
			angle_q  <= '0;
			offs_q   <= '0;
			center_q <= '0;
			colour_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_X_STEP: x_step_q <= cfg_data;
				REG_X_AMP:  x_amp_q  <= cfg_data[15:0];
				REG_Y_STEP: y_step_q <= cfg_data;
				REG_Y_AMP:  y_amp_q  <= cfg_data[15:0];
				REG_OFFS:   offs_q   <= cfg_data[25:0];
				REG_ANGLE:  angle_q  <= cfg_data[15:0];
				REG_CENTER: center_q <= cfg_data[23:0];
				REG_COLOUR: colour_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.x_step = x_step_q;
		cfg.y_step = y_step_q;
		cfg.x_amp  = (x_amp_q > AMP_FULL) ? AMP_FULL : x_amp_q;
		cfg.y_amp  = (y_amp_q > AMP_FULL) ? AMP_FULL : y_amp_q;
		cfg.x_off  = $signed(offs_q[12:0]);
		cfg.y_off  = $signed(offs_q[25:13]);
		cfg.angle  = angle_q;
		cfg.cx     = center_q[11:0];
		cfg.cy     = center_q[23:12];
		cfg.red    = sat_colour(colour_q[7:0]);
		cfg.green  = sat_colour(colour_q[15:8]);
		cfg.blue   = sat_colour(colour_q[23:16]);
	end

endmodule

[sv/lswg_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lswg_mul
// Shared signed 34x34 multiplier with registered product.
// ----------------------------------------------------------------------------
module lswg_mul (
	input  logic               clk,
	input  lswg_pkg::mul_req_t req,
	output logic signed [67:0] prod
);
	import lswg_pkg::*;

	logic signed [67:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 68'(req.a) * 68'(req.b);
	end

	assign prod = prod_q;

endmodule

[sv/lswg_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lswg_seq
// Sequencer and datapath: rotation sine/cosine, two axes, rotation, output.
// ----------------------------------------------------------------------------
module lswg_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  lswg_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [11:0]        pos_x,
	output logic [11:0]        pos_y,
	output logic [4:0]         red_level,
	output logic [4:0]         green_level,
	output logic [4:0]         blue_level,
	output lswg_pkg::mul_req_t mul_req,
	input  logic signed [67:0] mul_prod
);
	import lswg_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_K0   = 5'd1;
	localparam logic [4:0] ST_K1   = 5'd2;
	localparam logic [4:0] ST_K2   = 5'd3;
	localparam logic [4:0] ST_K3   = 5'd4;
	localparam logic [4:0] ST_K4   = 5'd5;
	localparam logic [4:0] ST_K5   = 5'd6;
	localparam logic [4:0] ST_K6   = 5'd7;
	localparam logic [4:0] ST_K7   = 5'd8;
	localparam logic [4:0] ST_K8   = 5'd9;
	localparam logic [4:0] ST_K9   = 5'd10;
	localparam logic [4:0] ST_A0   = 5'd11;
	localparam logic [4:0] ST_A1   = 5'd12;
	localparam logic [4:0] ST_A2   = 5'd13;
	localparam logic [4:0] ST_A3   = 5'd14;
	localparam logic [4:0] ST_R0   = 5'd15;
	localparam logic [4:0] ST_R1   = 5'd16;
	localparam logic [4:0] ST_R2   = 5'd17;
	localparam logic [4:0] ST_R3   = 5'd18;
	localparam logic [4:0] ST_R4   = 5'd19;
	localparam logic [4:0] ST_DONE = 5'd20;

	logic [4:0]            state_q;
	logic                  kpass_q;     // 0: sine of angle, 1: cosine
	logic [2:0]            n_q;
	logic [PHASE_BITS-1:0] xph_q, yph_q;
	logic [31:0]           x_q, x2_q, t_q, p_q, q_q;
	logic signed [17:0]    sn_q, cs_q;
	logic [27:0]           m1_q;
	logic [11:0]           px_q, py_q;
	logic signed [39:0]    acc_q, rx_q;
	logic                  out_valid_q;
	logic [11:0]           pos_x_q, pos_y_q;
	logic [4:0]            red_q, green_q, blue_q;

	logic [1:0]         quad;
	logic [14:0]        kang;
	logic [31:0]        pdiff, qc, s_k;
	logic [31:0]        kv_raw;
	logic [16:0]        kv;
	logic [16:0]        s1;
	logic [27:0]        m1;
	logic signed [12:0] dx, dy;
	logic               accept, load_out;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		quad   = kpass_q ? cfg.angle[15:14] + 2'd1 : cfg.angle[15:14];
		kang   = quad[0] ? 15'd16384 - {1'b0, cfg.angle[13:0]} : {1'b0, cfg.angle[13:0]};
		pdiff  = p_q - mul_prod[31:0];
		qc     = q_q + ((pdiff >= 32'(KDIV[n_q])) ? 32'd1 : 32'd0);
		s_k    = mul_prod[61:30];
		kv_raw = (s_k + 32'd16384) >> 15;
		kv     = (kv_raw > 32'(AMP_FULL)) ? 17'(AMP_FULL) : kv_raw[16:0];
		s1     = (state_q == ST_A0) ? WAVE_LUT[wave_index(xph_q)]
		                            : WAVE_LUT[wave_index(yph_q)];
		m1     = {s1, 11'd0} - 28'(s1);
		dx     = $signed({1'b0, px_q}) - $signed({1'b0, cfg.cx});
		dy     = $signed({1'b0, py_q}) - $signed({1'b0, cfg.cy});
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_req.a = '0;
		mul_req.b = '0;
		unique case (state_q)
			ST_K0: begin
				mul_req.a = 34'(kang);
				mul_req.b = 34'(PI_HALF_Q30);
			end
			ST_K1: begin
				mul_req.a = 34'(mul_prod[45:14]);
				mul_req.b = 34'(mul_prod[45:14]);
			end
			ST_K3: begin
				mul_req.a = 34'(x2_q);
				mul_req.b = 34'(t_q);
			end
			ST_K4: begin
				mul_req.a = 34'(mul_prod[61:30]);
				mul_req.b = 34'(KREC[n_q]);
			end
			ST_K5: begin
				mul_req.a = 34'(mul_prod[63:32]);
				mul_req.b = 34'(KDIV[n_q]);
			end
			ST_K8: begin
				mul_req.a = 34'(x_q);
				mul_req.b = 34'(t_q);
			end
			ST_A1: begin
				mul_req.a = 34'(m1_q);
				mul_req.b = 34'(cfg.x_amp);
			end
			ST_A2: begin
				mul_req.a = 34'(m1_q);
				mul_req.b = 34'(cfg.y_amp);
			end
			ST_R0: begin
				mul_req.a = 34'(dx);
				mul_req.b = 34'(cs_q);
			end
			ST_R1: begin
				mul_req.a = 34'(dy);
				mul_req.b = 34'(sn_q);
			end
			ST_R2: begin
				mul_req.a = 34'(dx);
				mul_req.b = 34'(sn_q);
			end
			ST_R3: begin
				mul_req.a = 34'(dy);
				mul_req.b = 34'(cs_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kpass_q     <= 1'b0;
			n_q         <= '0;
			xph_q       <= '0;
			yph_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (accept) begin
					if (restart) begin
						xph_q <= '0;
						yph_q <= '0;
					end
					kpass_q <= 1'b0;
					state_q <= ST_K0;
				end
				ST_K0: state_q <= ST_K1;
				ST_K1: state_q <= ST_K2;
				ST_K2: begin
					n_q     <= '0;
					state_q <= ST_K3;
				end
				ST_K3: state_q <= ST_K4;
				ST_K4: state_q <= ST_K5;
				ST_K5: state_q <= ST_K6;
				ST_K6: state_q <= ST_K7;
				ST_K7: begin
					n_q     <= n_q + 3'd1;
					state_q <= (n_q == 3'd4) ? ST_K8 : ST_K3;
				end
				ST_K8: state_q <= ST_K9;
				ST_K9: begin
					kpass_q <= 1'b1;
					state_q <= kpass_q ? ST_A0 : ST_K0;
				end
				ST_A0: state_q <= ST_A1;
				ST_A1: state_q <= ST_A2;
				ST_A2: state_q <= ST_A3;
				ST_A3: state_q <= ST_R0;
				ST_R0: state_q <= ST_R1;
				ST_R1: state_q <= ST_R2;
				ST_R2: state_q <= ST_R3;
				ST_R3: state_q <= ST_R4;
				ST_R4: state_q <= ST_DONE;
				ST_DONE: if (load_out) begin
					xph_q       <= xph_q + align_step(cfg.x_step);
					yph_q       <= yph_q + align_step(cfg.y_step);
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_K1: x_q <= mul_prod[45:14];
			ST_K2: begin
				x2_q <= mul_prod[61:30];
				t_q  <= Q30_ONE;
			end
			ST_K4: p_q <= mul_prod[61:30];
			ST_K5: q_q <= mul_prod[63:32];
			ST_K6: q_q <= qc;
			ST_K7: t_q <= (q_q > Q30_ONE) ? 32'd0 : Q30_ONE - q_q;
			ST_K9: begin
				if (kpass_q) cs_q <= quad[1] ? -18'(kv) : 18'(kv);
				else         sn_q <= quad[1] ? -18'(kv) : 18'(kv);
			end
			ST_A0: m1_q <= m1;
			ST_A1: m1_q <= m1;
			ST_A2: px_q <= axis_pos(mul_prod[42:0], cfg.x_off);
			ST_A3: py_q <= axis_pos(mul_prod[42:0], cfg.y_off);
			ST_R1: acc_q <= $signed({13'd0, cfg.cx, 15'd0}) + 40'(mul_prod);
			ST_R2: acc_q <= acc_q - 40'(mul_prod);
			ST_R3: begin
				rx_q  <= acc_q;
				acc_q <= $signed({13'd0, cfg.cy, 15'd0}) + 40'(mul_prod);
			end
			ST_R4: acc_q <= acc_q + 40'(mul_prod);
			ST_DONE: if (load_out) begin
				pos_x_q <= round_clamp(rx_q);
				pos_y_q <= round_clamp(acc_q);
				red_q   <= cfg.red;
				green_q <= cfg.green;
				blue_q  <= cfg.blue;
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign red_level   = red_q;
	assign green_level = green_q;
	assign blue_level  = blue_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_K0)
		else $error("accepted beat did not start the sequence");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_valid_q && !out_ready |=> state_q == ST_DONE)
		else $error("result overwrote a stalled output beat");

	a_load_presents: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finished result not presented");

endmodule

[sv/laser_scan_waveform_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_scan_waveform_generator_top
// Lissajous X/Y point source for a laser scanner with rotation and colour.
// ----------------------------------------------------------------------------
// Usage:
//   Program the eight registers over the cfg channel (index 0..7, data in the
//   low bits; other indexes are dropped). Write only while no tick is in work.
//   Each beat on the input channel is one sample tick; restart=1 clears both
//   phase accumulators before that tick is evaluated. Each tick yields exactly
//   one output beat: pos_x, pos_y and the three saturated colour levels.
//   A new tick is taken only after the previous point has moved into the
//   output register. The single shared multiplier serialises the work: the
//   rotation sine and cosine each run a 30-step series evaluation, then the
//   two axis products and four rotation products follow, one multiply at a time.
//   The output register holds a finished point while the next tick is taken;
//   if the receiver still stalls when that next point is done, the sequencer
//   holds in its final step and in_ready stays low until the beat is taken.
//   Reset clears the phases, the config registers, the sequencer state and the output valid flag.
// ----------------------------------------------------------------------------
module laser_scan_waveform_generator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lswg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lswg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             restart,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [11:0]                      pos_x,
	output logic [11:0]                      pos_y,
	output logic [4:0]                       red_level,
	output logic [4:0]                       green_level,
	output logic [4:0]                       blue_level
);
	import lswg_pkg::*;

	cfg_t               cfg;
	mul_req_t           mul_req;
	logic signed [67:0] mul_prod;

	// register file: decode and saturate fields once
	lswg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the one arithmetic unit, product registered and ready in the cycle after the request
	lswg_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (mul_prod)
	);

	// sequencer: advance through series, axis and rotation steps
	lswg_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level),
		.mul_req     (mul_req),
		.mul_prod    (mul_prod)
	);

endmodule

[bench/tb_laser_scan_waveform_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_laser_scan_waveform_generator_top
// Self-checking bench for the Lissajous scan point generator.
// ----------------------------------------------------------------------------
// Each sample tick sent to the block is scored against an in-bench model of
// the two phase accumulators, the series-based sine, axis scaling with signed
// offsets, rotation about a center and colour saturation. Points the block
// returns are compared field by field with the oldest predicted point. Both
// channels idle at random under three profiles, the receiver is held off for a
// long stretch once, and the registers are rewritten between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module tb_laser_scan_waveform_generator_top;
	import lswg_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat at all
	localparam int DRAIN_CYCLES   = 80;    // settle time after the last point is back
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd200;

	typedef struct {
		logic [11:0] px;
		logic [11:0] py;
		logic [4:0]  red;
		logic [4:0]  green;
		logic [4:0]  blue;
	} scan_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [11:0] pos_x, pos_y;
	logic [4:0] red_level, green_level, blue_level;

	// model copy of the registers and accumulators
	logic [31:0] m_x_step, m_y_step, m_x_phase, m_y_phase;
	logic [15:0] m_x_amp, m_y_amp, m_angle;
	logic [25:0] m_offsets;
	logic [23:0] m_center, m_colour;

	scan_point_t point_q[$];
	int errors = 0;
	int idle_in_pct = 0;
	int idle_out_pct = 0;
	int out_hold = 0;
	int quiet_cycles = 0;

	laser_scan_waveform_generator_top uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model
	// Odd Taylor series to x^11 in Q30, Horner with truncation, to Q1.15.
	function automatic longint unsigned series_sin(longint unsigned x);
		longint unsigned x2, t, q, s;
		longint unsigned dv[5];
		dv = '{110, 72, 42, 20, 6};
		x2 = (x * x) >> 30;
		t  = 64'd1 << 30;
		for (int n = 0; n < 5; n++) begin
			q = ((x2 * t) >> 30) / dv[n];
			t = (q > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - q;
		end
		s = (x * t) >> 30;
		q = (s + 64'd16384) >> 15;
		return (q > 64'd32768) ? 64'd32768 : q;
	endfunction

	function automatic longint quadrant_sin(int unsigned quad, longint unsigned r,
	                                        longint unsigned span);
		longint unsigned k;
		longint v;
		k = (quad & 1) ? span - r : r;
		v = longint'(series_sin((k * 64'd1686629713) / span));
		return (quad & 2) ? -v : v;
	endfunction

	function automatic longint axis_level(logic [31:0] ph, logic [15:0] amp,
	                                      logic [12:0] off);
		longint unsigned idx, span, a, s1, v;
		longint sum;
		span = SINE_TABLE_DEPTH / 4;
		idx  = (longint'(ph) * SINE_TABLE_DEPTH) >> PHASE_BITS;
		a    = (amp > 16'd32768) ? 64'd32768 : longint'(amp);
		s1   = longint'(quadrant_sin((idx / span) & 3, idx % span, span) + 32768);
		v    = (s1 * 64'd2047 * a + (64'd1 << 29)) >> 30;
		sum  = longint'(v) + longint'($signed(off));
		if (sum < 0) sum = 0;
		if (sum > 4095) sum = 4095;
		return sum;
	endfunction

	function automatic logic [11:0] settle_q15(longint q);
		longint v;
		if (q < 0) return 12'd0;
		v = (q + 16384) >>> 15;
		return (v > 4095) ? 12'd4095 : 12'(v);
	endfunction

	function automatic logic [4:0] clip_colour(logic [7:0] c);
		return (c > 8'd31) ? 5'd31 : c[4:0];
	endfunction

	// Work out one point, then advance both phases.
	task automatic predict_point(logic rs);
		scan_point_t p;
		longint px, py, cx, cy, dx, dy, sn, cs;
		int unsigned aq;
		if (rs) begin
			m_x_phase = '0;
			m_y_phase = '0;
		end
		px = axis_level(m_x_phase, m_x_amp, m_offsets[12:0]);
		py = axis_level(m_y_phase, m_y_amp, m_offsets[25:13]);
		aq = m_angle[15:14];
		sn = quadrant_sin(aq, m_angle[13:0], 64'h4000);
		cs = quadrant_sin((aq + 1) & 3, m_angle[13:0], 64'h4000);
		cx = m_center[11:0];
		cy = m_center[23:12];
		dx = px - cx;
		dy = py - cy;
		p.px    = settle_q15(cx * 32768 + dx * cs - dy * sn);
		p.py    = settle_q15(cy * 32768 + dx * sn + dy * cs);
		p.red   = clip_colour(m_colour[7:0]);
		p.green = clip_colour(m_colour[15:8]);
		p.blue  = clip_colour(m_colour[23:16]);
		point_q.push_back(p);
		m_x_phase += m_x_step;
		m_y_phase += m_y_step;
	endtask

	function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		case (idx)
			REG_X_STEP: m_x_step = d;
			REG_X_AMP:  m_x_amp = d[15:0];
			REG_Y_STEP: m_y_step = d;
			REG_Y_AMP:  m_y_amp = d[15:0];
			REG_OFFS:   m_offsets = d[25:0];
			REG_ANGLE:  m_angle = d[15:0];
			REG_CENTER: m_center = d[23:0];
			REG_COLOUR: m_colour = d[23:0];
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------- channels
	// Offer one tick; hold valid and restart until the beat is taken.
	task automatic send_tick(logic rs);
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_point(rs);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		store_reg(idx, d);
	endtask

	// Drop the input, wait for every point, then let the pipeline settle.
	task automatic drain_points();
		in_valid <= 1'b0;
		while (point_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_all(logic [31:0] xs, logic [31:0] xa, logic [31:0] ys,
	                           logic [31:0] ya, logic [31:0] off, logic [31:0] ang,
	                           logic [31:0] ctr, logic [31:0] col);
		drain_points();
		write_reg(REG_X_STEP, xs);
		write_reg(REG_X_AMP, xa);
		write_reg(REG_Y_STEP, ys);
		write_reg(REG_Y_AMP, ya);
		write_reg(REG_OFFS, off);
		write_reg(REG_ANGLE, ang);
		write_reg(REG_CENTER, ctr);
		write_reg(REG_COLOUR, col);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls, or a forced hold-off counted down here.
	always @(posedge clk) begin
		if (out_hold > 0) begin
			out_ready <= 1'b0;
			out_hold <= out_hold - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_out_pct);
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Score every output beat against the oldest predicted point.
	always @(posedge clk) begin
		scan_point_t e;
		if (arst_n && out_valid && out_ready) begin
			if (point_q.size() == 0) begin
				report_mismatch("unexpected point", 1, 0);
			end else begin
				e = point_q.pop_front();
				if (pos_x !== e.px) report_mismatch("pos_x", pos_x, e.px);
				if (pos_y !== e.py) report_mismatch("pos_y", pos_y, e.py);
				if (red_level !== e.red) report_mismatch("red_level", red_level, e.red);
				if (green_level !== e.green)
					report_mismatch("green_level", green_level, e.green);
				if (blue_level !== e.blue) report_mismatch("blue_level", blue_level, e.blue);
			end
		end
	end

	// Watchdog: end the run if no beat moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
		    || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- tests
	// All registers at reset: zero amplitude, no rotation, black.
	task automatic test_reset_values();
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
	endtask

	// Field extremes, amplitude and colour saturation, all four rotation
	// quadrants, offset limits, restart in mid-sweep and an unused index.
	task automatic test_directed();
		program_all(32'hFFFF_FFFF, 32'd32768, 32'h0400_0000, 32'd65535,
		            {6'd0, 13'h0FFF, 13'h1000}, 32'h0000, 32'hFFF_FFF, 32'hFF_FF_FF);
		repeat (4) send_tick(1'b0);
		send_tick(1'b1);
		program_all(32'h0200_0000, 32'd65535, 32'hFFFF_FFFF, 32'd32768,
		            {6'd0, 13'h1000, 13'h0FFF}, 32'h4000, 32'h800_800, 32'h1F_20_00);
		repeat (3) send_tick(1'b0);
		program_all(32'h1000_0000, 32'd16384, 32'h1000_0000, 32'd32767,
		            32'hFFFF_FFFF, 32'h8000, 32'h000_000, 32'h00_1F_1E);
		repeat (3) send_tick(1'b0);
		program_all(32'h0, 32'd1, 32'h0, 32'd0, 32'h0, 32'hC000, 32'h7FF_001, 32'h01_02_03);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		send_tick(1'b1);
		send_tick(1'b0);
		program_all(32'h0123_4567, 32'd32768, 32'h89AB_CDEF, 32'd32768,
		            32'h0, 32'hFFFF, 32'hFFF_000, 32'h20_1F_FF);
		repeat (4) send_tick(1'b0);
		send_tick(1'b1);
	endtask

	task automatic test_random_sweeps();
		logic [31:0] xs, ys, xa, ya;
		for (int blk = 0; blk < 6; blk++) begin
			// mostly full-range steps, some slow sweeps, some extremes
			xs = $urandom >> $urandom_range(0, 12);
			ys = $urandom >> $urandom_range(0, 12);
			if ($urandom_range(5) == 0) xs = 32'hFFFF_FFFF;
			if ($urandom_range(5) == 0) ys = 32'd0;
			xa = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32768);
			ya = ($urandom_range(3) == 0) ? 32'd32768 : $urandom_range(0, 32768);
			program_all(xs, xa, ys, ya, $urandom, $urandom, $urandom,
			            ($urandom_range(1) != 0) ? $urandom : ($urandom & 32'h3F_3F_3F));
			repeat (50) send_tick($urandom_range(9) == 0);
		end
	endtask

	// Hold the receiver off so the block fills and stalls its input.
	task automatic test_output_hold();
		drain_points();
		out_hold = 400;
		repeat (6) send_tick(1'($urandom_range(1)));
		// pause until every point is back, then resume
		drain_points();
		repeat (4) send_tick(1'b0);
	endtask

	initial begin
		m_x_step = '0; m_y_step = '0; m_x_phase = '0; m_y_phase = '0;
		m_x_amp = '0; m_y_amp = '0; m_angle = '0; m_offsets = '0;
		m_center = '0; m_colour = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed();
		idle_in_pct = 6;  idle_out_pct = 77;
		test_random_sweeps();
		idle_in_pct = 77; idle_out_pct = 6;
		test_random_sweeps();
		idle_in_pct = 0;  idle_out_pct = 0;
		test_random_sweeps();
		test_output_hold();

		drain_points();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[files.f]
sv/lswg_pkg.sv
sv/lswg_cfg.sv
sv/lswg_mul.sv
sv/lswg_seq.sv
sv/laser_scan_waveform_generator_top.sv
bench/tb_laser_scan_waveform_generator_top.sv
